@@ rtl/rgbhsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Types and constants shared by the RGB to HSL conversion pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int CompW     = 8;
    localparam int SatNumW   = 16;            // 255 * diff
    localparam int HueNumW   = 14;            // 42 * delta
    localparam int SatQw     = 8;
    localparam int HueQw     = 6;             // quotient never exceeds 42
    localparam int DivStages = 4;             // two quotient bits per stage

    localparam int SegSteps   = 42;
    localparam int SatScale   = 255;
    localparam int SumFull    = 510;
    localparam int GreenBase  = 84;
    localparam int BlueBase   = 168;
    localparam logic [CompW-1:0] CompMax = 8'hFF;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [CompW-1:0] hue;
        logic [CompW-1:0] saturation;
        logic [CompW-1:0] lightness;
    } hsl_t;

    // first stage: extremes and the hue delta of the winning sector
    typedef struct packed {
        max_sel_t         sel;
        logic             neg;
        logic [CompW-1:0] mag;
        logic [CompW-1:0] diff;
        logic [CompW:0]   sum;
    } extreme_t;

    // working set carried through the division stages
    typedef struct packed {
        logic [CompW-1:0]   light;
        max_sel_t           sel;
        logic               neg;
        logic [SatNumW-1:0] sat_rem;
        logic [CompW-1:0]   sat_den;
        logic [SatQw-1:0]   sat_q;
        logic [HueNumW-1:0] hue_rem;
        logic [CompW-1:0]   hue_den;
        logic [HueQw-1:0]   hue_q;
    } div_work_t;

endpackage

@@ rtl/rgbhsl_prep.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_prep
// Two pipeline stages: blue nudge, max/min, sector select, then the scaled
// numerators, the divisors and the lightness.
// ----------------------------------------------------------------------------
module rgbhsl_prep
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_stall,
    input  rgbhsl_pkg::pix_t   up_data,
    output logic               dn_valid,
    input  logic               dn_stall,
    output rgbhsl_pkg::div_work_t dn_data
);
    import rgbhsl_pkg::*;

    logic      s1_valid_reg;
    extreme_t  s1_reg;
    extreme_t  s1_next;
    logic      s1_stall;
    logic      s2_valid_reg;
    div_work_t s2_reg;
    div_work_t s2_next;
    logic      s2_stall;

    logic [CompW-1:0] blue_adj;
    logic [CompW-1:0] mx;
    logic [CompW-1:0] mn;
    logic [CompW-1:0] opa;
    logic [CompW-1:0] opb;

    // stage 1
    always_comb
    begin
        if (up_data.green == up_data.blue)
        begin
            blue_adj = (up_data.blue == CompMax) ? up_data.blue - 8'd1
                                                 : up_data.blue + 8'd1;
        end
        else
        begin
            blue_adj = up_data.blue;
        end

        mx = (up_data.red > blue_adj) ? up_data.red : blue_adj;
        mx = (mx > up_data.green) ? mx : up_data.green;
        mn = (up_data.red < blue_adj) ? up_data.red : blue_adj;
        mn = (mn < up_data.green) ? mn : up_data.green;

        // red wins ties, then green
        if (mx == up_data.red)
        begin
            s1_next.sel = MAX_RED;
            opa         = up_data.green;
            opb         = blue_adj;
        end
        else if (mx == up_data.green)
        begin
            s1_next.sel = MAX_GREEN;
            opa         = blue_adj;
            opb         = up_data.red;
        end
        else
        begin
            s1_next.sel = MAX_BLUE;
            opa         = up_data.red;
            opb         = up_data.green;
        end

        s1_next.neg  = opa < opb;
        s1_next.mag  = (opa < opb) ? opb - opa : opa - opb;
        s1_next.diff = mx - mn;
        s1_next.sum  = {1'b0, mx} + {1'b0, mn};
    end

    // stage 2
    always_comb
    begin
        s2_next.light   = s1_reg.sum[CompW:1];
        s2_next.sel     = s1_reg.sel;
        s2_next.neg     = s1_reg.neg;
        s2_next.sat_rem = SatNumW'(s1_reg.diff) * SatNumW'(SatScale);
        // lightness of 128 or more divides by the distance from full scale
        s2_next.sat_den = s1_reg.sum[CompW] ? CompW'(10'(SumFull) - 10'(s1_reg.sum))
                                            : s1_reg.sum[CompW-1:0];
        s2_next.sat_q   = '0;
        s2_next.hue_rem = HueNumW'(s1_reg.mag) * HueNumW'(SegSteps);
        s2_next.hue_den = s1_reg.diff;
        s2_next.hue_q   = '0;
    end

    assign s2_stall = s2_valid_reg && dn_stall;
    assign s1_stall = s1_valid_reg && s2_stall;
    assign up_stall = s1_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_stall)
            begin
                s1_valid_reg <= up_valid;
            end
            if (!s2_stall)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall && up_valid)
        begin
            s1_reg <= s1_next;
        end
        if (!s2_stall && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_data  = s2_reg;

`ifndef NO_ASSERTIONS
    // the blue nudge keeps every pixel off the gray axis
    a_diff_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_reg.diff != '0)
        else $error("extreme difference is zero");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_reg.sat_den != '0 && s2_reg.hue_den != '0))
        else $error("zero divisor entered the divider");
`endif

endmodule

@@ rtl/rgbhsl_div_stage.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_div_stage
// One register stage of the restoring dividers: two quotient bits for
// saturation and up to two for hue (none left in the last stage).
// ----------------------------------------------------------------------------
module rgbhsl_div_stage
#(
    parameter int STAGE = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  rgbhsl_pkg::div_work_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output rgbhsl_pkg::div_work_t dn_data
);
    import rgbhsl_pkg::*;

    localparam int SatK0  = SatQw - 1 - 2 * STAGE;
    localparam int SatK1  = SatK0 - 1;
    localparam bit SatOn0 = SatK0 >= 0;
    localparam bit SatOn1 = SatK1 >= 0;
    localparam int SatS0  = SatOn0 ? SatK0 : 0;
    localparam int SatS1  = SatOn1 ? SatK1 : 0;
    localparam int HueK0  = HueQw - 1 - 2 * STAGE;
    localparam int HueK1  = HueK0 - 1;
    localparam bit HueOn0 = HueK0 >= 0;
    localparam bit HueOn1 = HueK1 >= 0;
    localparam int HueS0  = HueOn0 ? HueK0 : 0;
    localparam int HueS1  = HueOn1 ? HueK1 : 0;

    logic      valid_reg;
    div_work_t work_reg;
    div_work_t work_next;
    logic      stall_int;

    logic [SatNumW-1:0] sat_d0;
    logic [SatNumW-1:0] sat_d1;
    logic [HueNumW-1:0] hue_d0;
    logic [HueNumW-1:0] hue_d1;

    always_comb
    begin
        work_next = up_data;
        sat_d0    = SatNumW'(up_data.sat_den) << SatS0;
        sat_d1    = SatNumW'(up_data.sat_den) << SatS1;
        hue_d0    = HueNumW'(up_data.hue_den) << HueS0;
        hue_d1    = HueNumW'(up_data.hue_den) << HueS1;

        if (SatOn0 && work_next.sat_rem >= sat_d0)
        begin
            work_next.sat_rem        = work_next.sat_rem - sat_d0;
            work_next.sat_q[SatS0]   = 1'b1;
        end
        if (SatOn1 && work_next.sat_rem >= sat_d1)
        begin
            work_next.sat_rem        = work_next.sat_rem - sat_d1;
            work_next.sat_q[SatS1]   = 1'b1;
        end
        if (HueOn0 && work_next.hue_rem >= hue_d0)
        begin
            work_next.hue_rem        = work_next.hue_rem - hue_d0;
            work_next.hue_q[HueS0]   = 1'b1;
        end
        if (HueOn1 && work_next.hue_rem >= hue_d1)
        begin
            work_next.hue_rem        = work_next.hue_rem - hue_d1;
            work_next.hue_q[HueS1]   = 1'b1;
        end
    end

    assign stall_int = valid_reg && dn_stall;
    assign up_stall  = stall_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall_int)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_int && up_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = work_reg;

endmodule

@@ rtl/rgbhsl_finish.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_finish
// Output register: places the hue quotient in its sector and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rgbhsl_finish
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_stall,
    input  rgbhsl_pkg::div_work_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_stall,
    output rgbhsl_pkg::hsl_t      dn_data
);
    import rgbhsl_pkg::*;

    logic             valid_reg;
    hsl_t             out_reg;
    hsl_t             out_next;
    logic             stall_int;
    logic [CompW-1:0] q;
    logic [CompW-1:0] base;

    always_comb
    begin
        q = CompW'(up_data.hue_q);
        case (up_data.sel)
            MAX_RED:   base = '0;
            MAX_GREEN: base = CompW'(GreenBase);
            MAX_BLUE:  base = CompW'(BlueBase);
            default:   base = '0;
        endcase
        // negative red-sector hue wraps modulo 256
        out_next.hue        = up_data.neg ? base - q : base + q;
        out_next.saturation = up_data.sat_q;
        out_next.lightness  = up_data.light;
    end

    assign stall_int = valid_reg && dn_stall;
    assign up_stall  = stall_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!stall_int)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_int && up_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = out_reg;

`ifndef NO_ASSERTIONS
    // after the last division stage the remainders are below their divisors
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid |-> (SatNumW'(up_data.sat_den) > up_data.sat_rem &&
                      HueNumW'(up_data.hue_den) > up_data.hue_rem))
        else $error("division remainder out of range");

    a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> out_reg.saturation != '0)
        else $error("saturation of zero on a nudged pixel");
`endif

endmodule

@@ rtl/rgb_to_hsl_integer.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_integer
// Converts 8-bit RGB pixels to integer hue, saturation and lightness.
// ----------------------------------------------------------------------------
// One pixel enters per clock unless the pipeline is full and stalled. Each
// pixel passes through two front stages (extremes, then the scaled
// numerators), four stages of the restoring dividers that resolve up to
// two quotient bits each, and the output register.
// A stall only holds the stages that are full, so bubbles close up and
// pixels keep entering until the pipeline is full.
module rgb_to_hsl_integer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  rgbhsl_pkg::pix_t  pix,
    output logic              hsl_valid,
    input  logic              hsl_stall,
    output rgbhsl_pkg::hsl_t  hsl
);
    import rgbhsl_pkg::*;

    logic      st_valid [DivStages+1];
    logic      st_stall [DivStages+1];
    div_work_t st_data  [DivStages+1];

    rgbhsl_prep u_prep
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_stall (pix_stall),
        .up_data  (pix),
        .dn_valid (st_valid[0]),
        .dn_stall (st_stall[0]),
        .dn_data  (st_data[0])
    );

    for (genvar i = 0; i < DivStages; i++)
    begin : g_div
        rgbhsl_div_stage #(.STAGE(i)) u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[i]),
            .up_stall (st_stall[i]),
            .up_data  (st_data[i]),
            .dn_valid (st_valid[i+1]),
            .dn_stall (st_stall[i+1]),
            .dn_data  (st_data[i+1])
        );
    end

    rgbhsl_finish u_finish
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid[DivStages]),
        .up_stall (st_stall[DivStages]),
        .up_data  (st_data[DivStages]),
        .dn_valid (hsl_valid),
        .dn_stall (hsl_stall),
        .dn_data  (hsl)
    );

endmodule
